// File: hw/rtl/hftd_pkg.sv
// Shared types, widths and defaults for the Huffman tree byte decoder.
`timescale 1ns / 1ps

package hftd_pkg;

	// Fixed field widths of the item and result beats.
	localparam int ACT_W    = 2;
	localparam int NODE_W   = 8;
	localparam int BRANCH_W = 16;
	localparam int CLEN_W   = 24;
	localparam int BYTE_W   = 8;
	localparam int ENTRY_W  = 2 * BRANCH_W;

	// Branch entries below this value are symbols; others point to a node.
	localparam int SYMBOL_LIMIT = 256;

	// Parameter defaults for the top level.
	localparam int NODE_COUNT_DEF   = 255;
	localparam int LENGTH_WIDTH_DEF = 24;

	// Item actions.
	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE_NODE = 2'd0,
		ACT_START      = 2'd1,
		ACT_DATA       = 2'd2
	} action_t;

	// One input beat.
	typedef struct packed {
		logic [ACT_W-1:0]    action;
		logic [NODE_W-1:0]   node_index;
		logic [BRANCH_W-1:0] branch_zero;
		logic [BRANCH_W-1:0] branch_one;
		logic [CLEN_W-1:0]   chunk_length;
		logic [BYTE_W-1:0]   data_byte;
	} in_item_t;

	// One result beat.
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last_of_run;
		logic              chunk_done;
		logic              bad_code;
	} out_item_t;

endpackage

// File: hw/rtl/hftd_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
`timescale 1ns / 1ps

interface hftd_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/hftd_node_mem.sv
// Node table memory: one write port and one registered read port.
`timescale 1ns / 1ps

module hftd_node_mem #(
	parameter int NODE_COUNT = hftd_pkg::NODE_COUNT_DEF,
	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [hftd_pkg::ENTRY_W-1:0] wdata,
	input  logic                         re,
	input  logic [AW-1:0]                raddr,
	output logic [hftd_pkg::ENTRY_W-1:0] rdata
);

	logic [hftd_pkg::ENTRY_W-1:0] mem [NODE_COUNT];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/hftd_walker.sv
// Tree walk sequencer with pending result and output register.
`timescale 1ns / 1ps

module hftd_walker #(
	parameter int NODE_COUNT   = hftd_pkg::NODE_COUNT_DEF,
	parameter int LENGTH_WIDTH = hftd_pkg::LENGTH_WIDTH_DEF,
	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	hftd_stream_if.sink                  items,
	hftd_stream_if.source                results,
	output logic                         mem_we,
	output logic [AW-1:0]                mem_waddr,
	output logic [hftd_pkg::ENTRY_W-1:0] mem_wdata,
	output logic                         mem_re,
	output logic [AW-1:0]                mem_raddr,
	input  logic [hftd_pkg::ENTRY_W-1:0] mem_rdata
);

	localparam int NW = hftd_pkg::NODE_W;
	localparam int BW = hftd_pkg::BRANCH_W;
	localparam int LW = LENGTH_WIDTH;
	localparam logic [NW-1:0] HEAD_NODE = NW'(NODE_COUNT - 1);
	localparam logic [NW:0]   NODE_LIM  = (NW + 1)'(NODE_COUNT);
	localparam logic [BW:0]   PTR_LIMIT = (BW + 1)'(hftd_pkg::SYMBOL_LIMIT + NODE_COUNT);
	localparam logic [2:0]    LAST_BIT  = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_WALK  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t                state_q;
	logic [NW-1:0]         cur_node_q;
	logic [LW-1:0]         bytes_left_q;
	logic                  active_q;
	logic [2:0]            bit_q;
	logic [7:0]            data_q;
	logic                  pend_valid_q;
	hftd_pkg::out_item_t   pend_q;
	logic                  out_valid_q;
	hftd_pkg::out_item_t   out_q;

	logic                  accept;
	logic [LW-1:0]         start_len;
	logic                  out_free;
	logic [BW-1:0]         entry;
	logic                  is_sym;
	logic                  is_bad;
	logic                  hit;
	logic                  stall;
	logic                  last_sym;
	logic                  ends;
	logic                  walk_fin;
	logic [NW-1:0]         next_node;
	logic                  step;
	logic                  pend_push;
	logic                  flush_go;
	logic                  out_load;

	// Input handshake: one item at a time, taken only between walks.
	assign items.ready = (state_q == ST_IDLE);
	assign accept      = items.valid && (state_q == ST_IDLE);
	assign start_len   = LW'(items.payload.chunk_length);

	// Table writes go straight to the memory; out-of-range nodes are dropped.
	assign mem_we    = accept && (items.payload.action == hftd_pkg::ACT_WRITE_NODE)
		&& ({1'b0, items.payload.node_index} < NODE_LIM);
	assign mem_waddr = items.payload.node_index[AW-1:0];
	assign mem_wdata = {items.payload.branch_one, items.payload.branch_zero};

	// Decode the branch taken by the current bit.
	assign out_free = !out_valid_q || results.ready;
	assign entry    = data_q[bit_q] ? mem_rdata[2*BW-1:BW] : mem_rdata[BW-1:0];
	assign is_sym   = (entry[BW-1:8] == '0);
	assign is_bad   = !is_sym && ({1'b0, entry} >= PTR_LIMIT);
	assign hit      = is_sym || is_bad;
	assign stall    = hit && pend_valid_q && !out_free;
	assign last_sym = is_sym && (bytes_left_q == LW'(1));
	assign ends     = is_bad || last_sym;
	assign walk_fin = (bit_q == LAST_BIT) || ends;
	assign next_node = hit ? HEAD_NODE : entry[NW-1:0];

	assign step      = (state_q == ST_WALK) && !stall;
	assign pend_push = step && hit;
	assign flush_go  = (state_q == ST_FLUSH) && out_free;
	assign out_load  = (pend_push && pend_valid_q) || flush_go;

	// Node reads: the first at byte entry, then one per bit from the walk.
	assign mem_re = (accept && (items.payload.action == hftd_pkg::ACT_DATA) && active_q)
		|| (step && !walk_fin);
	assign mem_raddr = (state_q == ST_IDLE) ? cur_node_q[AW-1:0] : next_node[AW-1:0];

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_node_q   <= HEAD_NODE;
			bytes_left_q <= '0;
			active_q     <= 1'b0;
			bit_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						priority if (items.payload.action == hftd_pkg::ACT_START) begin
							bytes_left_q <= start_len;
							cur_node_q   <= HEAD_NODE;
							active_q     <= (start_len != '0);
						end else if (items.payload.action == hftd_pkg::ACT_DATA && active_q) begin
							bit_q   <= '0;
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (!stall) begin
						cur_node_q <= next_node;
						bit_q      <= bit_q + 3'd1;
						if (hit) begin
							pend_valid_q <= 1'b1;
						end
						if (is_sym) begin
							bytes_left_q <= bytes_left_q - LW'(1);
						end
						if (ends) begin
							active_q <= 1'b0;
						end
						if (walk_fin) begin
							state_q <= (hit || pend_valid_q) ? ST_FLUSH : ST_IDLE;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: byte under walk, pending result, output beat.
	always_ff @(posedge clk) begin
		if (accept && (items.payload.action == hftd_pkg::ACT_DATA)) begin
			data_q <= items.payload.data_byte;
		end
		if (pend_push) begin
			pend_q <= {(is_sym ? entry[7:0] : 8'd0), 1'b0, last_sym, is_bad};
		end
		if (pend_push && pend_valid_q) begin
			out_q <= pend_q;
		end else if (flush_go) begin
			out_q <= {pend_q.out_byte, 1'b1, pend_q.chunk_done, pend_q.bad_code};
		end
	end

	assign results.valid   = out_valid_q;
	assign results.payload = out_q;

	// The walk position always names a node inside the table.
	a_node_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_node_q <= HEAD_NODE)
		else $error("walk position beyond node table");

	// An active chunk always has bytes still owed.
	a_active_len: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (bytes_left_q != '0))
		else $error("active chunk with zero length left");

	// Every walk leaves its last result flushed before the next item.
	a_idle_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("pending result left behind at idle");

	// An error beat carries no symbol and does not complete the chunk.
	a_bad_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.bad_code) |-> (!out_q.chunk_done && out_q.out_byte == 8'd0))
		else $error("malformed error beat");

endmodule

// File: hw/rtl/huffman_tree_byte_decoder_core.sv
// Top level of the Huffman tree byte decoder: node memory plus walk sequencer.
//
//   Channel   Dir   Payload                          Beat taken when
//   items     in    hftd_pkg::in_item_t              items.valid && items.ready
//   results   out   hftd_pkg::out_item_t             results.valid && results.ready
//
// A data byte is walked bit by bit, up to eight bits, and each bit needs one
// node memory read; the FLUSH state then hands the last pending result of the
// byte to the output register. A full output register with a result pending
// stalls the walk when a bit reaches a symbol or a bad code.
// Reset clears the walk state; the node table holds nothing until written.
`timescale 1ns / 1ps

module huffman_tree_byte_decoder_core #(
	parameter int NODE_COUNT   = hftd_pkg::NODE_COUNT_DEF,
	parameter int LENGTH_WIDTH = hftd_pkg::LENGTH_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	hftd_stream_if.sink   items,
	hftd_stream_if.source results
);

	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	logic [hftd_pkg::ENTRY_W-1:0] mem_wdata;
	logic                         mem_re;
	logic [AW-1:0]                mem_raddr;
	logic [hftd_pkg::ENTRY_W-1:0] mem_rdata;

	// Node table.
	hftd_node_mem #(
		.NODE_COUNT (NODE_COUNT)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Walk sequencer and result staging.
	hftd_walker #(
		.NODE_COUNT   (NODE_COUNT),
		.LENGTH_WIDTH (LENGTH_WIDTH)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.results   (results),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule
